/* sv/zhne_pkg.sv */
// zhne_pkg: constants shared by the ZIP local-header name extractor.
// Holds the signature bytes, the header byte positions and the skip limit reset.
// No dependencies.
package zhne_pkg;

  // Local file header signature, in stream order
  localparam logic [7:0] SIG_B0 = 8'h50;
  localparam logic [7:0] SIG_B1 = 8'h4b;
  localparam logic [7:0] SIG_B2 = 8'h03;
  localparam logic [7:0] SIG_B3 = 8'h04;

  // Signature bytes checked after the first one
  localparam int unsigned SIG_TAIL = 3;

  // Header positions (counted after the increment for the current byte)
  localparam int unsigned POS_SIZE_B0    = 'h12;
  localparam int unsigned POS_SIZE_B1    = 'h13;
  localparam int unsigned POS_SIZE_B2    = 'h14;
  localparam int unsigned POS_SIZE_B3    = 'h15;
  localparam int unsigned POS_NAME_LO    = 'h1a;
  localparam int unsigned POS_NAME_HI    = 'h1b;
  localparam int unsigned POS_EXTRA_LO   = 'h1c;
  localparam int unsigned POS_EXTRA_HI   = 'h1d;
  localparam int unsigned POS_NAME_START = 'h1e;

  // Reset value of the skip limit
  localparam logic [31:0] MAX_SKIP_RESET = 32'd10485760;

endpackage

/* sv/zip_header_name_extractor_unit.sv */
// zip_header_name_extractor_unit: ZIP local-header parser that streams out filenames.
// Depends on zhne_pkg for signature bytes and header positions.
//
// The block takes one archive byte per clock cycle with no bubbles: each request is
// parsed in the cycle it is accepted and its result, if any, lands in a single output
// register. in_ready is high whenever that register is empty or being drained this
// cycle, so throughput is one byte per cycle while out_ready stays high; a stalled
// result holds off input for exactly as long as it waits. A byte yields at most one
// result: a filename character with its index, or an end-of-name item (name_done high,
// byte and index zero). Header bytes, skipped data and a bad signature yield nothing.
// The skip limit cfg register is written with cfg_wr_en; a byte parsed in that cycle sees the old one.
module zip_header_name_extractor_unit #(
  parameter int unsigned NAME_BUF = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  // name items out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_name_byte,
  output logic [7:0]  out_name_index,
  output logic        out_name_done,
  output logic [7:0]  out_name_length
);

  localparam int unsigned HPW = $clog2(NAME_BUF + 31);
  localparam int unsigned NLW = $clog2(NAME_BUF);

  localparam logic [HPW-1:0] HP_SIG_TAIL   = HPW'(zhne_pkg::SIG_TAIL);
  localparam logic [HPW-1:0] HP_SIZE_B0    = HPW'(zhne_pkg::POS_SIZE_B0);
  localparam logic [HPW-1:0] HP_SIZE_B1    = HPW'(zhne_pkg::POS_SIZE_B1);
  localparam logic [HPW-1:0] HP_SIZE_B2    = HPW'(zhne_pkg::POS_SIZE_B2);
  localparam logic [HPW-1:0] HP_SIZE_B3    = HPW'(zhne_pkg::POS_SIZE_B3);
  localparam logic [HPW-1:0] HP_NAME_LO    = HPW'(zhne_pkg::POS_NAME_LO);
  localparam logic [HPW-1:0] HP_NAME_HI    = HPW'(zhne_pkg::POS_NAME_HI);
  localparam logic [HPW-1:0] HP_EXTRA_LO   = HPW'(zhne_pkg::POS_EXTRA_LO);
  localparam logic [HPW-1:0] HP_EXTRA_HI   = HPW'(zhne_pkg::POS_EXTRA_HI);
  localparam logic [HPW-1:0] HP_NAME_START = HPW'(zhne_pkg::POS_NAME_START);
  localparam logic [NLW-1:0] NAME_MAX      = NLW'(NAME_BUF - 1);

  // parser state
  logic           hunting_r,  hunting_nxt;
  logic [HPW-1:0] hpos_r,     hpos_nxt;
  logic           skipping_r, skipping_nxt;
  logic [31:0]    skip_r,     skip_nxt;
  logic [NLW-1:0] name_len_r, name_len_nxt;
  logic [7:0]     name_lo_r,  name_lo_nxt;
  logic [31:0]    max_skip_r;

  // result register
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r;
  logic [7:0]     out_index_r;
  logic           out_done_r;
  logic [7:0]     out_len_r;

  // per-byte work signals
  logic           accept;
  logic           emit;
  logic           emit_done;
  logic [7:0]     emit_byte;
  logic           restart;
  logic [HPW-1:0] hp1;
  logic [HPW-1:0] idx;
  logic [15:0]    name_full;
  logic [31:0]    size_sum;
  logic [HPW+7:0] idx_ext;
  logic [NLW+7:0] len_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign hp1       = hpos_r + HPW'(1);
  assign idx       = hp1 - HP_NAME_START;
  assign name_full = {in_data_byte, name_lo_r};
  assign size_sum  = skip_r + {16'h0000, in_data_byte, 8'h00};
  assign idx_ext   = {8'h00, idx};
  assign len_ext   = {8'h00, name_len_r};

  // parse one byte; restart means clear state and re-examine the byte as a hunt
  always_comb begin
    hunting_nxt  = hunting_r;
    hpos_nxt     = hpos_r;
    skipping_nxt = skipping_r;
    skip_nxt     = skip_r;
    name_len_nxt = name_len_r;
    name_lo_nxt  = name_lo_r;
    emit         = 1'b0;
    emit_done    = 1'b0;
    emit_byte    = 8'h00;
    restart      = 1'b0;

    if (skipping_r) begin
      if (skip_r == 32'd0) begin
        restart = 1'b1;
      end else begin
        skip_nxt = skip_r - 32'd1;
      end
    end else if (hunting_r) begin
      if (in_data_byte == zhne_pkg::SIG_B0) begin
        hunting_nxt = 1'b0;
        hpos_nxt    = '0;
      end
    end else if (hpos_r < HP_SIG_TAIL) begin
      // rest of the signature, no overlap retry on a mismatch
      if ((hpos_r == HPW'(0) && in_data_byte == zhne_pkg::SIG_B1) ||
          (hpos_r == HPW'(1) && in_data_byte == zhne_pkg::SIG_B2) ||
          (hpos_r == HPW'(2) && in_data_byte == zhne_pkg::SIG_B3)) begin
        hpos_nxt = hp1;
      end else begin
        hunting_nxt = 1'b1;
        hpos_nxt    = '0;
      end
    end else begin
      hpos_nxt = hp1;
      if (hp1 == HP_SIZE_B0) begin
        skip_nxt = {24'h000000, in_data_byte};
      end else if (hp1 == HP_SIZE_B1) begin
        skip_nxt = skip_r | {16'h0000, in_data_byte, 8'h00};
      end else if (hp1 == HP_SIZE_B2) begin
        skip_nxt = skip_r | {8'h00, in_data_byte, 16'h0000};
      end else if (hp1 == HP_SIZE_B3) begin
        skip_nxt = skip_r | {in_data_byte, 24'h000000};
      end else if (hp1 == HP_NAME_LO) begin
        name_lo_nxt = in_data_byte;
      end else if (hp1 == HP_NAME_HI) begin
        // clip the name length to the buffer
        if ({1'b0, name_full} >= 17'(NAME_BUF)) begin
          name_len_nxt = NAME_MAX;
        end else begin
          name_len_nxt = name_full[NLW-1:0];
        end
      end else if (hp1 == HP_EXTRA_LO) begin
        skip_nxt = skip_r + {24'h000000, in_data_byte};
      end else if (hp1 == HP_EXTRA_HI) begin
        if (size_sum > max_skip_r) begin
          restart = 1'b1;
        end else begin
          skip_nxt = size_sum;
        end
      end else if (hp1 >= HP_NAME_START) begin
        emit = 1'b1;
        if (idx >= HPW'(name_len_r)) begin
          // end of name: this byte is also the first one in skip mode
          emit_done    = 1'b1;
          skipping_nxt = 1'b1;
          if (skip_r == 32'd0) begin
            restart = 1'b1;
          end else begin
            skip_nxt = skip_r - 32'd1;
          end
        end else begin
          emit_byte = in_data_byte;
        end
      end
    end

    if (restart) begin
      hunting_nxt  = (in_data_byte != zhne_pkg::SIG_B0);
      hpos_nxt     = '0;
      skipping_nxt = 1'b0;
      skip_nxt     = 32'd0;
      name_len_nxt = '0;
    end
  end

  // output register: loads on an accepted request, drains on out_ready
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r   <= 1'b1;
      hpos_r      <= '0;
      skipping_r  <= 1'b0;
      skip_r      <= 32'd0;
      name_len_r  <= '0;
      max_skip_r  <= zhne_pkg::MAX_SKIP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_skip_r <= cfg_wr_data;
      end
      if (accept) begin
        hunting_r  <= hunting_nxt;
        hpos_r     <= hpos_nxt;
        skipping_r <= skipping_nxt;
        skip_r     <= skip_nxt;
        name_len_r <= name_len_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      name_lo_r <= name_lo_nxt;
    end
    if (accept && emit) begin
      out_byte_r  <= emit_byte;
      out_index_r <= emit_done ? 8'h00 : idx_ext[7:0];
      out_done_r  <= emit_done;
      out_len_r   <= len_ext[7:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_name_byte   = out_byte_r;
  assign out_name_index  = out_index_r;
  assign out_name_done   = out_done_r;
  assign out_name_length = out_len_r;

endmodule

/* sv/zhne_checker.sv */
// zhne_checker: port-level assertions for zip_header_name_extractor_unit.
// Bound to the top level at the end of this file; uses no package.
module zhne_checker #(
  parameter int unsigned NAME_BUF = 256
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_name_byte,
  input logic [7:0] out_name_index,
  input logic       out_name_done,
  input logic [7:0] out_name_length
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_name_byte) &&
      $stable(out_name_index) && $stable(out_name_done) && $stable(out_name_length))
    else $error("result changed while stalled");

  // input is held off only while a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output register");

  // end-of-name items carry zero byte and index
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_name_done |-> out_name_byte == 8'h00 && out_name_index == 8'h00)
    else $error("end-of-name item with nonzero byte or index");

  // with NAME_BUF up to 256, a character index lies below the clipped name length
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_name_done |-> (NAME_BUF > 256) || (out_name_index < out_name_length))
    else $error("name index beyond name length");

endmodule

bind zip_header_name_extractor_unit zhne_checker #(.NAME_BUF(NAME_BUF)) u_zhne_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_name_byte   (out_name_byte),
  .out_name_index  (out_name_index),
  .out_name_done   (out_name_done),
  .out_name_length (out_name_length)
);
